// ===== rtl/core/sbc_pkg.sv =====
// Shared types and constants for the sphere versus box classifier.
`default_nettype none

package sbc_pkg;

  // Result codes carried on the output stream
  typedef enum logic [1:0] {
    REL_OUTSIDE    = 2'd0,
    REL_INTERSECTS = 2'd1,
    REL_INSIDE     = 2'd2
  } relation_t;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_X      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Y      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Z      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPHERE_RADIUS = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FAST_MODE     = 3'd4;

  localparam int unsigned OUT_DATA_BITS = 8;
  localparam int unsigned AXES          = 3;

  // Where the centre sits relative to one slab of the box
  typedef struct packed {
    logic below;   // centre below the box minimum
    logic above;   // centre above the box maximum
  } slab_side_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbc_diff.sv =====
// Stages 1 and 2: per-axis corner offsets from the centre and their magnitudes.
`default_nettype none

module sbc_diff #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic [sbc_pkg::AXES-1:0][COORD_BITS-1:0]  box_lo,
  input  wire logic [sbc_pkg::AXES-1:0][COORD_BITS-1:0]  box_hi,
  input  wire logic [sbc_pkg::AXES-1:0][COORD_BITS-1:0]  center,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic [sbc_pkg::AXES-1:0][COORD_BITS:0]         mag_lo,
  output logic [sbc_pkg::AXES-1:0][COORD_BITS:0]         mag_hi,
  output sbc_pkg::slab_side_t [sbc_pkg::AXES-1:0]        side
);

  localparam int DW = COORD_BITS + 1;

  logic                             v1;
  logic                             v2;
  logic                             ready1;
  logic                             ready2;
  logic [sbc_pkg::AXES-1:0][DW-1:0] dl;
  logic [sbc_pkg::AXES-1:0][DW-1:0] dh;

  assign ready2    = !v2 || out_ready;
  assign ready1    = !v1 || ready2;
  assign in_ready  = ready1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
    end
  end

  // Offsets are exact in one extra bit
  always_ff @(posedge clk) begin
    if (ready1) begin
      for (int a = 0; a < sbc_pkg::AXES; a++) begin
        dl[a] <= {box_lo[a][COORD_BITS-1], box_lo[a]} - {center[a][COORD_BITS-1], center[a]};
        dh[a] <= {box_hi[a][COORD_BITS-1], box_hi[a]} - {center[a][COORD_BITS-1], center[a]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      for (int a = 0; a < sbc_pkg::AXES; a++) begin
        mag_lo[a]     <= dl[a][DW-1] ? -dl[a] : dl[a];
        mag_hi[a]     <= dh[a][DW-1] ? -dh[a] : dh[a];
        side[a].below <= !dl[a][DW-1] && (dl[a] != '0);
        side[a].above <= dh[a][DW-1];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sbc_square.sv =====
// Stage 3: squares of the per-axis offset magnitudes.
`default_nettype none

module sbc_square #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        in_valid,
  output logic                                             in_ready,
  input  wire logic [sbc_pkg::AXES-1:0][COORD_BITS:0]      mag_lo,
  input  wire logic [sbc_pkg::AXES-1:0][COORD_BITS:0]      mag_hi,
  input  wire sbc_pkg::slab_side_t [sbc_pkg::AXES-1:0]     side_in,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output logic [sbc_pkg::AXES-1:0][2*COORD_BITS+1:0]       sq_lo,
  output logic [sbc_pkg::AXES-1:0][2*COORD_BITS+1:0]       sq_hi,
  output sbc_pkg::slab_side_t [sbc_pkg::AXES-1:0]          side_out
);

  localparam int SQW = 2 * (COORD_BITS + 1);

  logic v3;
  logic ready3;

  assign ready3    = !v3 || out_ready;
  assign in_ready  = ready3;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      for (int a = 0; a < sbc_pkg::AXES; a++) begin
        sq_lo[a] <= SQW'(mag_lo[a]) * SQW'(mag_lo[a]);
        sq_hi[a] <= SQW'(mag_hi[a]) * SQW'(mag_hi[a]);
      end
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sbc_reduce.sv =====
// Stages 4 and 5: nearest-point and farthest-corner squared distances.
`default_nettype none

module sbc_reduce #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic [sbc_pkg::AXES-1:0][2*COORD_BITS+1:0] sq_lo,
  input  wire logic [sbc_pkg::AXES-1:0][2*COORD_BITS+1:0] sq_hi,
  input  wire sbc_pkg::slab_side_t [sbc_pkg::AXES-1:0]   side,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic [2*COORD_BITS+3:0]                        near_sum,
  output logic [2*COORD_BITS+3:0]                        far_sum
);

  localparam int SQW = 2 * (COORD_BITS + 1);
  localparam int SW  = SQW + 2;

  logic                              v4;
  logic                              v5;
  logic                              ready4;
  logic                              ready5;
  logic [sbc_pkg::AXES-1:0][SQW-1:0] near;
  logic [sbc_pkg::AXES-1:0][SQW-1:0] far;

  assign ready5    = !v5 || out_ready;
  assign ready4    = !v4 || ready5;
  assign in_ready  = ready4;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (ready4) v4 <= in_valid;
      if (ready5) v5 <= v4;
    end
  end

  // The farthest corner takes the larger square on every axis, so one sum
  // covers all eight corners. Below-minimum wins on an inverted slab.
  always_ff @(posedge clk) begin
    if (ready4) begin
      for (int a = 0; a < sbc_pkg::AXES; a++) begin
        if (side[a].below) begin
          near[a] <= sq_lo[a];
        end else if (side[a].above) begin
          near[a] <= sq_hi[a];
        end else begin
          near[a] <= '0;
        end
        far[a] <= (sq_lo[a] >= sq_hi[a]) ? sq_lo[a] : sq_hi[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready5) begin
      near_sum <= SW'(near[0]) + SW'(near[1]) + SW'(near[2]);
      far_sum  <= SW'(far[0]) + SW'(far[1]) + SW'(far[2]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sphere_box_classify_unit.sv =====
// Throughput: one box per cycle unless stalled by m_tready; six register stages
// (offsets, magnitudes, squares, per-axis select, sums, compare) each advance as
// soon as the stage ahead frees up.
// Squared radius is held in its own register, refreshed every cycle from the radius.
// Reset (rst, synchronous) empties the pipeline and clears all configuration to zero.
`default_nettype none

module sphere_box_classify_unit #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // relation
  output logic [sbc_pkg::OUT_DATA_BITS-1:0]           m_tdata,
  input  wire logic                                   cfg_wen,
  input  wire logic [sbc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [COORD_BITS-1:0]                  cfg_wdata
);

  localparam int SQW = 2 * (COORD_BITS + 1);
  localparam int SW  = SQW + 2;
  localparam int RW  = 2 * (COORD_BITS - 1);

  logic [sbc_pkg::AXES-1:0][COORD_BITS-1:0]  center;
  logic [COORD_BITS-2:0]                     sphere_radius;
  logic                                      fast_mode;
  logic [RW-1:0]                             radius_sq;

  logic [sbc_pkg::AXES-1:0][COORD_BITS-1:0]  box_lo;
  logic [sbc_pkg::AXES-1:0][COORD_BITS-1:0]  box_hi;

  logic                                      d_valid;
  logic                                      d_ready;
  logic [sbc_pkg::AXES-1:0][COORD_BITS:0]    mag_lo;
  logic [sbc_pkg::AXES-1:0][COORD_BITS:0]    mag_hi;
  sbc_pkg::slab_side_t [sbc_pkg::AXES-1:0]   d_side;

  logic                                      q_valid;
  logic                                      q_ready;
  logic [sbc_pkg::AXES-1:0][SQW-1:0]         sq_lo;
  logic [sbc_pkg::AXES-1:0][SQW-1:0]         sq_hi;
  sbc_pkg::slab_side_t [sbc_pkg::AXES-1:0]   q_side;

  logic                                      r_valid;
  logic                                      r_ready;
  logic [SW-1:0]                             near_sum;
  logic [SW-1:0]                             far_sum;

  logic                                      v6;
  sbc_pkg::relation_t                        relation;
  sbc_pkg::relation_t                        relation_next;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      center        <= '0;
      sphere_radius <= '0;
      fast_mode     <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        sbc_pkg::CFG_CENTER_X:      center[0]     <= cfg_wdata;
        sbc_pkg::CFG_CENTER_Y:      center[1]     <= cfg_wdata;
        sbc_pkg::CFG_CENTER_Z:      center[2]     <= cfg_wdata;
        sbc_pkg::CFG_SPHERE_RADIUS: sphere_radius <= cfg_wdata[COORD_BITS-2:0];
        sbc_pkg::CFG_FAST_MODE:     fast_mode     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    radius_sq <= RW'(sphere_radius) * RW'(sphere_radius);
  end

  always_comb begin
    for (int a = 0; a < sbc_pkg::AXES; a++) begin
      box_lo[a] = s_tdata[a*COORD_BITS +: COORD_BITS];
      box_hi[a] = s_tdata[(a+3)*COORD_BITS +: COORD_BITS];
    end
  end

  sbc_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .box_lo    (box_lo),
    .box_hi    (box_hi),
    .center    (center),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .mag_lo    (mag_lo),
    .mag_hi    (mag_hi),
    .side      (d_side)
  );

  sbc_square #(.COORD_BITS(COORD_BITS)) u_square (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .mag_lo    (mag_lo),
    .mag_hi    (mag_hi),
    .side_in   (d_side),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .sq_lo     (sq_lo),
    .sq_hi     (sq_hi),
    .side_out  (q_side)
  );

  sbc_reduce #(.COORD_BITS(COORD_BITS)) u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .sq_lo     (sq_lo),
    .sq_hi     (sq_hi),
    .side      (q_side),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .near_sum  (near_sum),
    .far_sum   (far_sum)
  );

  // Final compare and output register
  assign r_ready = !v6 || m_tready;

  always_comb begin
    if (near_sum >= SW'(radius_sq)) begin
      relation_next = sbc_pkg::REL_OUTSIDE;
    end else if (fast_mode) begin
      relation_next = sbc_pkg::REL_INSIDE;
    end else if (far_sum >= SW'(radius_sq)) begin
      relation_next = sbc_pkg::REL_INTERSECTS;
    end else begin
      relation_next = sbc_pkg::REL_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (r_ready) begin
      v6 <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r_ready) begin
      relation <= relation_next;
    end
  end

  assign m_tvalid = v6;
  assign m_tdata  = sbc_pkg::OUT_DATA_BITS'(relation);

endmodule

`default_nettype wire

// ===== sim/sphere_box_classify_unit_tb.sv =====
// Self-checking testbench for the sphere versus box classifier: directed table, then random boxes.
module sphere_box_classify_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 24;
  localparam int C_MAX = 8388607;
  localparam int C_MIN = -8388608;
  localparam int UNIT = 4096;                  // 1.0 in Q12.12
  localparam int PIPE_DRAIN = 10;              // extra wait once no results are due, past the six-stage pipeline
  localparam int RANDOM_PHASES = 8;
  localparam int BOXES_PER_PHASE = 231;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam int REPORT_CAP = 100;
  // Indexes with no register behind them
  localparam logic [sbc_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [sbc_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_HI = 3'd7;

  // Packed so that box_min_x lands in the lowest bits of s_tdata
  typedef struct packed {
    logic [COORD_BITS-1:0] max_z;
    logic [COORD_BITS-1:0] max_y;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] min_z;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] min_x;
  } box_t;

  typedef struct {
    bit                                 is_write;
    logic [sbc_pkg::CFG_INDEX_BITS-1:0] idx;
    logic [COORD_BITS-1:0]              wdata;
    box_t                               box;
    bit                                 typed;
    sbc_pkg::relation_t                 want;
  } plan_row_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [6*COORD_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b1;
  logic [sbc_pkg::OUT_DATA_BITS-1:0] m_tdata;
  logic cfg_wen = 1'b0;
  logic [sbc_pkg::CFG_INDEX_BITS-1:0] cfg_index = sbc_pkg::CFG_CENTER_X;
  logic [COORD_BITS-1:0] cfg_wdata = '0;

  // Shadow copy of the sphere registers
  logic [COORD_BITS-1:0] centre [3] = '{default: '0};
  logic [COORD_BITS-2:0] radius = '0;
  logic fast = 1'b0;

  sbc_pkg::relation_t relation_due [$];
  plan_row_t plan [$];
  int mismatches = 0;
  longint cycles = 0;
  bit tx_quiet = 1'b0;

  // receiver stall state
  int rx_hold = 0;
  int rx_stretch = 0;
  bit rx_quiet = 1'b0;

  sphere_box_classify_unit #(.COORD_BITS(COORD_BITS)) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic sbc_pkg::relation_t classify_box(box_t b);
    longint c [3];
    longint lo [3];
    longint hi [3];
    longint r2, gap2, d2, p;
    c[0] = longint'($signed(centre[0]));
    c[1] = longint'($signed(centre[1]));
    c[2] = longint'($signed(centre[2]));
    lo[0] = longint'($signed(b.min_x));
    lo[1] = longint'($signed(b.min_y));
    lo[2] = longint'($signed(b.min_z));
    hi[0] = longint'($signed(b.max_x));
    hi[1] = longint'($signed(b.max_y));
    hi[2] = longint'($signed(b.max_z));
    r2 = longint'(radius) * longint'(radius);
    gap2 = 0;
    // below-min is tested first, so an inverted slab still follows that order
    for (int a = 0; a < 3; a++) begin
      if (c[a] < lo[a])
        gap2 += (c[a] - lo[a]) * (c[a] - lo[a]);
      else if (c[a] > hi[a])
        gap2 += (c[a] - hi[a]) * (c[a] - hi[a]);
    end
    if (gap2 >= r2)
      return sbc_pkg::REL_OUTSIDE;
    if (fast)
      return sbc_pkg::REL_INSIDE;
    for (int k = 0; k < 8; k++) begin
      d2 = 0;
      for (int a = 0; a < 3; a++) begin
        p = ((k >> a) & 1) ? hi[a] : lo[a];
        d2 += (p - c[a]) * (p - c[a]);
      end
      if (d2 >= r2)
        return sbc_pkg::REL_INTERSECTS;
    end
    return sbc_pkg::REL_INSIDE;
  endfunction

  function automatic box_t mk_box(int mnx, int mny, int mnz, int mxx, int mxy, int mxz);
    box_t b;
    b.min_x = mnx[COORD_BITS-1:0];
    b.min_y = mny[COORD_BITS-1:0];
    b.min_z = mnz[COORD_BITS-1:0];
    b.max_x = mxx[COORD_BITS-1:0];
    b.max_y = mxy[COORD_BITS-1:0];
    b.max_z = mxz[COORD_BITS-1:0];
    return b;
  endfunction

  // Boxes mostly scaled to the current radius so that all three relations turn up
  function automatic box_t rand_box();
    longint c, s, lo, hi, t;
    logic [COORD_BITS-1:0] mn [3];
    logic [COORD_BITS-1:0] mx [3];
    int kind;
    box_t b;
    s = (radius == 0) ? 64 : longint'(radius);
    kind = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      c = longint'($signed(centre[a]));
      case (kind)
        0, 1, 2: begin
          lo = c - longint'($urandom_range(0, int'(s / 2)));
          hi = c + longint'($urandom_range(0, int'(s / 2)));
        end
        3, 4, 5, 6, 7: begin
          lo = c + longint'($urandom_range(0, int'(4 * s))) - 2 * s;
          hi = lo + longint'($urandom_range(0, int'(2 * s)));
          if (kind == 7) begin
            t = lo;
            lo = hi;
            hi = t;
          end
        end
        default: begin
          lo = longint'($urandom);
          hi = longint'($urandom);
        end
      endcase
      mn[a] = lo[COORD_BITS-1:0];
      mx[a] = hi[COORD_BITS-1:0];
    end
    b.min_x = mn[0];
    b.min_y = mn[1];
    b.min_z = mn[2];
    b.max_x = mx[0];
    b.max_y = mx[1];
    b.max_z = mx[2];
    return b;
  endfunction

  function automatic void add_write(logic [sbc_pkg::CFG_INDEX_BITS-1:0] idx,
                                    logic [COORD_BITS-1:0] d);
    plan_row_t r;
    r.is_write = 1'b1;
    r.idx = idx;
    r.wdata = d;
    r.box = '0;
    r.typed = 1'b0;
    r.want = sbc_pkg::REL_OUTSIDE;
    plan.push_back(r);
  endfunction

  function automatic void add_box(box_t b, bit typed, sbc_pkg::relation_t want);
    plan_row_t r;
    r.is_write = 1'b0;
    r.idx = sbc_pkg::CFG_CENTER_X;
    r.wdata = '0;
    r.box = b;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  // Leaves cfg_wen high; the caller lowers it after the last write of a batch
  task automatic write_reg(logic [sbc_pkg::CFG_INDEX_BITS-1:0] idx, logic [COORD_BITS-1:0] d);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    case (idx)
      sbc_pkg::CFG_CENTER_X:      centre[0] = d;
      sbc_pkg::CFG_CENTER_Y:      centre[1] = d;
      sbc_pkg::CFG_CENTER_Z:      centre[2] = d;
      sbc_pkg::CFG_SPHERE_RADIUS: radius = d[COORD_BITS-2:0];
      sbc_pkg::CFG_FAST_MODE:     fast = d[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    cfg_wen <= 1'b0;
    while (relation_due.size() != 0)
      @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic send_box(box_t b, bit typed, sbc_pkg::relation_t want);
    int n;
    if (!tx_quiet && $urandom_range(0, 3) == 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    relation_due.push_back(typed ? want : classify_box(b));
  endtask

  function automatic logic [COORD_BITS-1:0] rand_centre();
    case ($urandom_range(0, 5))
      0: return C_MIN[COORD_BITS-1:0];
      1: return C_MAX[COORD_BITS-1:0];
      2: return '0;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_radius();
    logic [COORD_BITS-1:0] r;
    case ($urandom_range(0, 9))
      0: r = '0;
      1: r = C_MAX[COORD_BITS-1:0];
      2, 3, 4, 5: r = COORD_BITS'($urandom_range(1, 4 * UNIT));
      default: r = COORD_BITS'($urandom);
    endcase
    r[COORD_BITS-1] = 1'($urandom_range(0, 1));  // surplus bit, must be dropped
    return r;
  endfunction

  // Receiver: stretches with and without back-pressure, stalls mostly short
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
      rx_hold <= 0;
      rx_stretch <= 0;
      rx_quiet <= 1'b0;
    end else begin
      if (rx_stretch == 0) begin
        rx_stretch <= $urandom_range(200, 800);
        rx_quiet <= ($urandom_range(0, 3) == 0);
      end else begin
        rx_stretch <= rx_stretch - 1;
      end
      if (rx_hold != 0) begin
        m_tready <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else if (!rx_quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39) : $urandom_range(0, 2);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sbc_pkg::relation_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (relation_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: unexpected transaction, expected none, got relation %0d",
                   $time, m_tdata[1:0]);
      end else begin
        want = relation_due.pop_front();
        if (m_tdata[1:0] !== want) begin
          mismatches++;
          // keep the log bounded on a badly broken design
          if (mismatches <= REPORT_CAP)
            $display("%0t: relation mismatch, expected %0d (%s), got %0d",
                     $time, want, want.name(), m_tdata[1:0]);
        end
      end
    end
  end

  initial begin
    bit writing;
    // After reset the radius is zero, so every box is outside
    add_box(mk_box(0, 0, 0, 0, 0, 0), 1'b1, sbc_pkg::REL_OUTSIDE);
    add_box(mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 1'b1, sbc_pkg::REL_OUTSIDE);
    add_box(mk_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 1'b1, sbc_pkg::REL_OUTSIDE);
    add_box(mk_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 1'b1, sbc_pkg::REL_OUTSIDE);
    add_box(mk_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN), 1'b1, sbc_pkg::REL_OUTSIDE);
    // unit sphere at the origin
    add_write(sbc_pkg::CFG_CENTER_X, '0);
    add_write(sbc_pkg::CFG_CENTER_Y, '0);
    add_write(sbc_pkg::CFG_CENTER_Z, '0);
    add_write(sbc_pkg::CFG_SPHERE_RADIUS, COORD_BITS'(UNIT));
    add_write(sbc_pkg::CFG_FAST_MODE, '0);
    add_box(mk_box(-1, -1, -1, 1, 1, 1), 1'b0, sbc_pkg::REL_OUTSIDE);
    add_box(mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 1'b0, sbc_pkg::REL_OUTSIDE);
    add_box(mk_box(2 * UNIT, 0, 0, 3 * UNIT, 0, 0), 1'b0, sbc_pkg::REL_OUTSIDE);
    // exactly on the surface
    add_box(mk_box(UNIT, 0, 0, UNIT, 0, 0), 1'b0, sbc_pkg::REL_OUTSIDE);
    add_box(mk_box(-2896, -2896, -2896, 2896, 2896, 2896), 1'b0, sbc_pkg::REL_OUTSIDE);
    // inverted slab
    add_box(mk_box(100, -100, -100, -100, 100, 100), 1'b0, sbc_pkg::REL_OUTSIDE);
    add_box(mk_box(5000, -100, -100, -5000, 100, 100), 1'b0, sbc_pkg::REL_OUTSIDE);
    add_write(sbc_pkg::CFG_FAST_MODE, COORD_BITS'(1));
    add_box(mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 1'b1, sbc_pkg::REL_INSIDE);
    add_box(mk_box(3 * UNIT, 3 * UNIT, 3 * UNIT, C_MAX, C_MAX, C_MAX), 1'b1,
            sbc_pkg::REL_OUTSIDE);
    // extreme centre, largest radius written with its surplus bit set
    add_write(sbc_pkg::CFG_CENTER_X, C_MAX[COORD_BITS-1:0]);
    add_write(sbc_pkg::CFG_CENTER_Y, C_MIN[COORD_BITS-1:0]);
    add_write(sbc_pkg::CFG_SPHERE_RADIUS, '1);
    add_write(sbc_pkg::CFG_FAST_MODE, '0);
    add_write(CFG_UNUSED_LO, '0);
    add_write(CFG_UNUSED_HI, '1);
    add_box(mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 1'b0, sbc_pkg::REL_OUTSIDE);
    add_box(mk_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 1'b0, sbc_pkg::REL_OUTSIDE);
    add_box(mk_box(C_MAX, C_MIN, 0, C_MAX, C_MIN, 0), 1'b0, sbc_pkg::REL_OUTSIDE);
    add_box(mk_box(C_MIN, C_MIN, 0, C_MAX, C_MIN, 0), 1'b0, sbc_pkg::REL_OUTSIDE);
    add_write(sbc_pkg::CFG_FAST_MODE, '1);
    add_box(mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 1'b1, sbc_pkg::REL_INSIDE);
    // zero radius wins over fast mode
    add_write(sbc_pkg::CFG_SPHERE_RADIUS, 24'h800000);
    add_box(mk_box(C_MAX, C_MIN, 0, C_MAX, C_MIN, 0), 1'b1, sbc_pkg::REL_OUTSIDE);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    writing = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!writing) begin
          drain();
          writing = 1'b1;
        end
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        if (writing) begin
          cfg_wen <= 1'b0;
          writing = 1'b0;
        end
        send_box(plan[i].box, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      write_reg(sbc_pkg::CFG_CENTER_X, rand_centre());
      write_reg(sbc_pkg::CFG_CENTER_Y, rand_centre());
      write_reg(sbc_pkg::CFG_CENTER_Z, rand_centre());
      write_reg(sbc_pkg::CFG_SPHERE_RADIUS, rand_radius());
      write_reg(sbc_pkg::CFG_FAST_MODE, COORD_BITS'($urandom));
      if ($urandom_range(0, 2) == 0)
        write_reg(sbc_pkg::CFG_INDEX_BITS'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                  COORD_BITS'($urandom));
      cfg_wen <= 1'b0;
      tx_quiet = ($urandom_range(0, 3) == 0);
      repeat (BOXES_PER_PHASE)
        send_box(rand_box(), 1'b0, sbc_pkg::REL_OUTSIDE);
    end

    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sbc_pkg.sv
rtl/core/sbc_diff.sv
rtl/core/sbc_square.sv
rtl/core/sbc_reduce.sv
rtl/core/sphere_box_classify_unit.sv
sim/sphere_box_classify_unit_tb.sv
